FILE: hw/rtl/lfi_pkg.sv
package lfi_pkg;

    // Rule table geometry
    localparam int RULE_DEPTH = 16;
    localparam int RULE_IDXW  = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int RULE_CNTW  = $clog2(RULE_DEPTH + 1);

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTRW  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNTW  = $clog2(Q_DEPTH + 1);

    // Configuration register indexes and reset values
    localparam logic CFG_IDX_DIR   = 1'b0;
    localparam logic CFG_IDX_DELAY = 1'b1;
    localparam logic [7:0] DELAY_TICKS_RST = 8'd8;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_SEND = 2'd1,
        KIND_POLL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FLT_DROP  = 2'd0,
        FLT_DELAY = 2'd1,
        FLT_DUP   = 2'd2,
        FLT_DISC  = 2'd3
    } t_rule_fault;

    typedef enum logic [2:0] {
        REP_NONE  = 3'd0,
        REP_DROP  = 3'd1,
        REP_DELAY = 3'd2,
        REP_DUP   = 3'd3,
        REP_DISC  = 3'd4
    } t_fault_rep;

    typedef enum logic [1:0] {
        ACT_FWD       = 2'd0,
        ACT_CLOSE     = 2'd1,
        ACT_SEND_DONE = 2'd2,
        ACT_ADD_DONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SEND = 2'd1,
        OP_POLL = 2'd2
    } t_op;

    // Result sequence chosen for one command
    typedef enum logic [2:0] {
        PLAN_ADD,
        PLAN_MISS,
        PLAN_DROP,
        PLAN_DELAY,
        PLAN_DUP,
        PLAN_DISC,
        PLAN_POLL
    } t_plan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_back_state;

    // One rule; for a send the same fields carry the packet type and sequence
    typedef struct packed {
        logic        dir;
        t_rule_fault fault;
        logic [2:0]  ptype;
        logic        need_seq;
        logic [31:0] seq;
    } t_rule;

    typedef struct packed {
        t_op   op;
        t_rule rule;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic       dir;
        logic [7:0] delay_ticks;
    } t_cfg;

endpackage

FILE: hw/rtl/lfi_in_if.sv
interface lfi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        direction;
    logic [1:0]  fault_kind;
    logic [2:0]  packet_type;
    logic        match_sequence;
    logic [31:0] sequence_req;

    modport source (
        output valid, kind, direction, fault_kind, packet_type, match_sequence, sequence_req,
        input  ready
    );
    modport sink (
        input  valid, kind, direction, fault_kind, packet_type, match_sequence, sequence_req,
        output ready
    );
endinterface

FILE: hw/rtl/lfi_out_if.sv
interface lfi_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  out_type;
    logic [31:0] out_sequence;
    logic        ok;
    logic [2:0]  fault_applied;
    logic [4:0]  rules_used;
    logic        last;

    modport source (
        output valid, action, out_type, out_sequence, ok, fault_applied, rules_used, last,
        input  ready
    );
    modport sink (
        input  valid, action, out_type, out_sequence, ok, fault_applied, rules_used, last,
        output ready
    );
endinterface

FILE: hw/rtl/lfi_ram.sv
module lfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/lfi_queue.sv
module lfi_queue
    import lfi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_push   i_push,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_stat
);
    t_cmd              r_mem [Q_DEPTH];
    logic [Q_PTRW-1:0] r_wr, n_wr;
    logic [Q_PTRW-1:0] r_rd, n_rd;
    logic [Q_CNTW-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == Q_CNTW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    assign do_push = i_push.push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == Q_PTRW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTRW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_PTRW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTRW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + Q_CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - Q_CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end
endmodule

FILE: hw/rtl/lfi_front.sv
module lfi_front
    import lfi_pkg::*;
(
    lfi_in_if.sink    i_in,
    input  t_q_status i_q_stat,
    output t_q_push   o_q_push
);
    logic accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // Classify the word; the unused kind code is taken and dropped
    always_comb begin
        o_q_push.cmd.rule.dir      = i_in.direction;
        o_q_push.cmd.rule.fault    = t_rule_fault'(i_in.fault_kind);
        o_q_push.cmd.rule.ptype    = i_in.packet_type;
        o_q_push.cmd.rule.need_seq = i_in.match_sequence;
        o_q_push.cmd.rule.seq      = i_in.sequence_req;
        o_q_push.cmd.op            = OP_ADD;
        o_q_push.push              = 1'b0;
        unique case (t_kind'(i_in.kind))
            KIND_ADD: begin
                o_q_push.cmd.op = OP_ADD;
                o_q_push.push   = accept;
            end
            KIND_SEND: begin
                o_q_push.cmd.op = OP_SEND;
                o_q_push.push   = accept;
            end
            KIND_POLL: begin
                o_q_push.cmd.op = OP_POLL;
                o_q_push.push   = accept;
            end
            default: begin
                o_q_push.push = 1'b0;
            end
        endcase
    end
endmodule

FILE: hw/rtl/lfi_back.sv
module lfi_back
    import lfi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_head,
    input  t_q_status i_q_stat,
    output logic      o_pop,
    lfi_out_if.source o_out
);
    // Control state
    t_back_state          r_state, n_state;
    logic [RULE_CNTW-1:0] r_rule_cnt, n_rule_cnt;
    logic [4:0]           r_used, n_used;
    logic                 r_pending, n_pending;
    logic [7:0]           r_remain, n_remain;
    logic [RULE_CNTW-1:0] r_scan_cnt, n_scan_cnt;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [1:0]           r_res_idx, n_res_idx;
    logic                 r_out_vld, n_out_vld;

    // Payload state
    logic [2:0]            r_held_type, n_held_type;
    logic [31:0]           r_held_seq, n_held_seq;
    logic [RULE_DEPTH-1:0] r_consumed, n_consumed;
    logic [RULE_IDXW-1:0]  r_cmp_idx, n_cmp_idx;
    logic [2:0]            r_cmd_type, n_cmd_type;
    logic [31:0]           r_cmd_seq, n_cmd_seq;
    t_plan                 r_plan, n_plan;
    logic                  r_stored, n_stored;
    t_action               r_out_action, n_out_action;
    logic [2:0]            r_out_type, n_out_type;
    logic [31:0]           r_out_seq, n_out_seq;
    logic                  r_out_ok, n_out_ok;
    t_fault_rep            r_out_fault, n_out_fault;
    logic [4:0]            r_out_used, n_out_used;
    logic                  r_out_last, n_out_last;

    // Rule memory
    logic                 ram_we;
    logic [RULE_IDXW-1:0] ram_waddr;
    logic [RULE_IDXW-1:0] ram_raddr;
    t_rule                ram_wdata;
    logic [$bits(t_rule)-1:0] ram_rdata;
    t_rule                rd_rule;

    logic       hit;
    logic       out_load;
    t_action    res_action;
    logic [2:0] res_type;
    logic [31:0] res_seq;
    logic       res_ok;
    t_fault_rep res_fault;
    logic       res_last;

    lfi_ram #(
        .WIDTH ($bits(t_rule)),
        .DEPTH (RULE_DEPTH)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_rule   = t_rule'(ram_rdata);
    assign ram_waddr = r_rule_cnt[RULE_IDXW-1:0];
    assign ram_wdata = i_head.rule;
    assign ram_raddr = r_scan_cnt[RULE_IDXW-1:0];

    // Compare stage: entry read last cycle against the packet
    assign hit = r_cmp_vld && !r_consumed[r_cmp_idx]
                 && (rd_rule.dir == i_cfg.dir)
                 && (rd_rule.ptype == r_cmd_type)
                 && (!rd_rule.need_seq || (rd_rule.seq == r_cmd_seq));

    assign out_load = (r_state == ST_EMIT) && (!r_out_vld || o_out.ready);

    // Result word for the current plan and result index
    always_comb begin
        res_action = ACT_SEND_DONE;
        res_type   = 3'd0;
        res_seq    = 32'd0;
        res_ok     = 1'b1;
        res_fault  = REP_NONE;
        res_last   = 1'b0;
        unique case (r_plan)
            PLAN_ADD: begin
                res_action = ACT_ADD_DONE;
                res_ok     = r_stored;
                res_last   = 1'b1;
            end
            PLAN_MISS: begin
                if (r_res_idx == 2'd0) begin
                    res_action = ACT_FWD;
                    res_type   = r_cmd_type;
                    res_seq    = r_cmd_seq;
                end else begin
                    res_last = 1'b1;
                end
            end
            PLAN_DROP: begin
                res_fault = REP_DROP;
                res_last  = 1'b1;
            end
            PLAN_DELAY: begin
                res_fault = REP_DELAY;
                res_last  = 1'b1;
            end
            PLAN_DUP: begin
                res_fault = REP_DUP;
                if (r_res_idx != 2'd2) begin
                    res_action = ACT_FWD;
                    res_type   = r_cmd_type;
                    res_seq    = r_cmd_seq;
                end else begin
                    res_last = 1'b1;
                end
            end
            PLAN_DISC: begin
                res_fault = REP_DISC;
                res_ok    = 1'b0;
                if (r_res_idx == 2'd0) begin
                    res_action = ACT_CLOSE;
                end else begin
                    res_last = 1'b1;
                end
            end
            PLAN_POLL: begin
                res_action = ACT_FWD;
                res_type   = r_cmd_type;
                res_seq    = r_cmd_seq;
                res_last   = 1'b1;
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    // Sequencer: take command, scan rules, emit results
    always_comb begin
        n_state     = r_state;
        n_rule_cnt  = r_rule_cnt;
        n_used      = r_used;
        n_pending   = r_pending;
        n_remain    = r_remain;
        n_scan_cnt  = r_scan_cnt;
        n_cmp_vld   = r_cmp_vld;
        n_res_idx   = r_res_idx;
        n_held_type = r_held_type;
        n_held_seq  = r_held_seq;
        n_consumed  = r_consumed;
        n_cmp_idx   = r_cmp_idx;
        n_cmd_type  = r_cmd_type;
        n_cmd_seq   = r_cmd_seq;
        n_plan      = r_plan;
        n_stored    = r_stored;
        o_pop       = 1'b0;
        ram_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        OP_ADD: begin
                            if (r_rule_cnt < RULE_CNTW'(RULE_DEPTH)) begin
                                ram_we = 1'b1;
                                n_consumed[r_rule_cnt[RULE_IDXW-1:0]] = 1'b0;
                                n_rule_cnt = r_rule_cnt + RULE_CNTW'(1);
                                n_stored   = 1'b1;
                            end else begin
                                n_stored = 1'b0;
                            end
                            n_plan    = PLAN_ADD;
                            n_res_idx = 2'd0;
                            n_state   = ST_EMIT;
                        end
                        OP_SEND: begin
                            n_cmd_type = i_head.rule.ptype;
                            n_cmd_seq  = i_head.rule.seq;
                            n_scan_cnt = '0;
                            n_cmp_vld  = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        OP_POLL: begin
                            if (r_pending) begin
                                if (r_remain != 8'd0) begin
                                    n_remain = r_remain - 8'd1;
                                end else begin
                                    // wait over: release the held packet
                                    n_pending  = 1'b0;
                                    n_cmd_type = r_held_type;
                                    n_cmd_seq  = r_held_seq;
                                    n_plan     = PLAN_POLL;
                                    n_res_idx  = 2'd0;
                                    n_state    = ST_EMIT;
                                end
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_consumed[r_cmp_idx] = 1'b1;
                    n_used    = r_used + 5'd1;
                    n_res_idx = 2'd0;
                    n_state   = ST_EMIT;
                    unique case (rd_rule.fault)
                        FLT_DROP:  n_plan = PLAN_DROP;
                        FLT_DELAY: begin
                            n_plan      = PLAN_DELAY;
                            n_pending   = 1'b1;
                            n_held_type = r_cmd_type;
                            n_held_seq  = r_cmd_seq;
                            n_remain    = i_cfg.delay_ticks;
                        end
                        FLT_DUP:   n_plan = PLAN_DUP;
                        default:   n_plan = PLAN_DISC;
                    endcase
                end else if (r_scan_cnt < r_rule_cnt) begin
                    // issue the next entry read
                    n_cmp_vld  = 1'b1;
                    n_cmp_idx  = r_scan_cnt[RULE_IDXW-1:0];
                    n_scan_cnt = r_scan_cnt + RULE_CNTW'(1);
                end else begin
                    n_plan    = PLAN_MISS;
                    n_res_idx = 2'd0;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_res_idx = r_res_idx + 2'd1;
                    if (res_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_vld    = r_out_vld;
        n_out_action = r_out_action;
        n_out_type   = r_out_type;
        n_out_seq    = r_out_seq;
        n_out_ok     = r_out_ok;
        n_out_fault  = r_out_fault;
        n_out_used   = r_out_used;
        n_out_last   = r_out_last;
        if (out_load) begin
            n_out_vld    = 1'b1;
            n_out_action = res_action;
            n_out_type   = res_type;
            n_out_seq    = res_seq;
            n_out_ok     = res_ok;
            n_out_fault  = res_fault;
            n_out_used   = r_used;
            n_out_last   = res_last;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rule_cnt  <= '0;
            r_used      <= '0;
            r_pending   <= 1'b0;
            r_remain    <= '0;
            r_scan_cnt  <= '0;
            r_cmp_vld   <= 1'b0;
            r_res_idx   <= '0;
            r_out_vld   <= 1'b0;
            r_held_type <= '0;
            r_held_seq  <= '0;
        end else begin
            r_state     <= n_state;
            r_rule_cnt  <= n_rule_cnt;
            r_used      <= n_used;
            r_pending   <= n_pending;
            r_remain    <= n_remain;
            r_scan_cnt  <= n_scan_cnt;
            r_cmp_vld   <= n_cmp_vld;
            r_res_idx   <= n_res_idx;
            r_out_vld   <= n_out_vld;
            r_held_type <= n_held_type;
            r_held_seq  <= n_held_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_consumed   <= n_consumed;
        r_cmp_idx    <= n_cmp_idx;
        r_cmd_type   <= n_cmd_type;
        r_cmd_seq    <= n_cmd_seq;
        r_plan       <= n_plan;
        r_stored     <= n_stored;
        r_out_action <= n_out_action;
        r_out_type   <= n_out_type;
        r_out_seq    <= n_out_seq;
        r_out_ok     <= n_out_ok;
        r_out_fault  <= n_out_fault;
        r_out_used   <= n_out_used;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.action        = r_out_action;
    assign o_out.out_type      = r_out_type;
    assign o_out.out_sequence  = r_out_seq;
    assign o_out.ok            = r_out_ok;
    assign o_out.fault_applied = r_out_fault;
    assign o_out.rules_used    = r_out_used;
    assign o_out.last          = r_out_last;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rule_cnt <= RULE_CNTW'(RULE_DEPTH))
        else $error("rule count beyond table depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_cnt <= r_rule_cnt))
        else $error("scan pointer past stored rules");

    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_IDLE) && o_pop && (i_head.op == OP_ADD)))
        else $error("rule write outside an add command");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && res_last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return after final word");
endmodule

FILE: hw/rtl/link_fault_injector.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    kind, direction, fault_kind, packet_type,
//                               match_sequence, sequence_req
// o_out     out  valid/ready    action, out_type, out_sequence, ok,
//                               fault_applied, rules_used, last
// i_cfg_*   in   write enable   i_cfg_idx selects register, i_cfg_data value
//
// A send is decided by a scan: the back end reads the rule memory one entry
// per cycle and compares the entry read in the previous cycle. Adds and polls
// are decided in the idle state; every result word then passes through the
// output register.
// Reset is synchronous, active low; the rule memory needs no clearing pass.
// A two-entry command queue lets the input side keep taking words while the
// back end scans or waits on a stalled output.
module link_fault_injector
    import lfi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfi_in_if.sink     i_in,
    lfi_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    logic       r_cfg_dir;
    logic [7:0] r_cfg_delay;
    t_cfg       cfg;
    t_q_push    q_push;
    t_q_status  q_stat;
    t_cmd       q_head;
    logic       q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dir   <= 1'b0;
            r_cfg_delay <= DELAY_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_DIR) begin
                r_cfg_dir <= i_cfg_data[0];
            end else if (i_cfg_idx == CFG_IDX_DELAY) begin
                r_cfg_delay <= i_cfg_data;
            end
        end
    end

    assign cfg.dir         = r_cfg_dir;
    assign cfg.delay_ticks = r_cfg_delay;

    lfi_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_q_push (q_push)
    );

    lfi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    lfi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );
endmodule

FILE: sim/lfi_checker.sv
module lfi_checker
    import lfi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfi_in_if          i_in,
    lfi_out_if         i_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_run_done,
    output int         o_fail_count,
    output int         o_pending
);

    // One stored rule plus its one-shot flag
    typedef struct {
        logic        dir;
        t_rule_fault fault;
        logic [2:0]  ptype;
        logic        need_seq;
        logic [31:0] seq;
        logic        spent;
    } t_rule_entry;

    // One output word as the block should present it
    typedef struct {
        t_action     action;
        logic [2:0]  ptype;
        logic [31:0] seq;
        logic        ok;
        t_fault_rep  fault;
        logic [4:0]  used;
        logic        last;
    } t_link_word;

    t_rule_entry rules [RULE_DEPTH];
    int          rule_cnt;
    logic [4:0]  spent_cnt;

    // Single delay slot
    logic        hold_valid;
    logic [7:0]  hold_wait;
    logic [2:0]  hold_type;
    logic [31:0] hold_seq;

    logic        chan_dir;
    logic [7:0]  delay_ticks;

    t_link_word  link_words [$];
    t_link_word  head;
    int          mismatches = 0;
    int          queued = 0;
    bit          done_seen = 0;

    // Coverage tallies for the closing summary
    int n_add = 0, n_refused = 0, n_send = 0, n_poll = 0, n_other = 0;
    int n_drop = 0, n_delay = 0, n_dup = 0, n_disc = 0, n_release = 0;
    int n_checked = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got 0x%0h, want 0x%0h (word %0d)",
                             name, got, want, n_checked));
        end
    endtask

    task automatic queue_word(input t_action a, input logic [2:0] t, input logic [31:0] s,
                              input logic ok, input t_fault_rep f, input logic last);
        t_link_word w;
        w = '{a, t, s, ok, f, spent_cnt, last};
        link_words.insert(link_words.size(), w);
    endtask

    // First unspent rule that matches the packet wins
    task automatic predict_send(input logic [2:0] ptype, input logic [31:0] seq);
        int hit;
        hit = -1;
        for (int i = 0; i < rule_cnt; i++) begin
            if (hit < 0 && !rules[i].spent && rules[i].dir == chan_dir &&
                rules[i].ptype == ptype && (!rules[i].need_seq || rules[i].seq == seq)) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            queue_word(ACT_FWD, ptype, seq, 1'b1, REP_NONE, 1'b0);
            queue_word(ACT_SEND_DONE, 3'd0, 32'd0, 1'b1, REP_NONE, 1'b1);
        end else begin
            rules[hit].spent = 1'b1;
            spent_cnt++;
            case (rules[hit].fault)
                FLT_DROP: begin
                    n_drop++;
                    queue_word(ACT_SEND_DONE, 3'd0, 32'd0, 1'b1, REP_DROP, 1'b1);
                end
                FLT_DELAY: begin
                    // a later delay simply overwrites the slot
                    n_delay++;
                    hold_valid = 1'b1;
                    hold_type  = ptype;
                    hold_seq   = seq;
                    hold_wait  = delay_ticks;
                    queue_word(ACT_SEND_DONE, 3'd0, 32'd0, 1'b1, REP_DELAY, 1'b1);
                end
                FLT_DUP: begin
                    n_dup++;
                    queue_word(ACT_FWD, ptype, seq, 1'b1, REP_DUP, 1'b0);
                    queue_word(ACT_FWD, ptype, seq, 1'b1, REP_DUP, 1'b0);
                    queue_word(ACT_SEND_DONE, 3'd0, 32'd0, 1'b1, REP_DUP, 1'b1);
                end
                FLT_DISC: begin
                    n_disc++;
                    queue_word(ACT_CLOSE, 3'd0, 32'd0, 1'b0, REP_DISC, 1'b0);
                    queue_word(ACT_SEND_DONE, 3'd0, 32'd0, 1'b0, REP_DISC, 1'b1);
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rule_cnt    = 0;
            spent_cnt   = '0;
            hold_valid  = 1'b0;
            hold_wait   = '0;
            hold_type   = '0;
            hold_seq    = '0;
            chan_dir    = 1'b0;
            delay_ticks = DELAY_TICKS_RST;
            link_words.delete();
        end else begin
            // Compare the accepted result word with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (link_words.size() == 0) begin
                    report($sformatf("result word with nothing pending (action %0d)",
                                     i_out.action));
                end else begin
                    head = link_words.pop_front();
                    check_field("action", i_out.action, head.action);
                    check_field("out_type", i_out.out_type, head.ptype);
                    check_field("out_sequence", i_out.out_sequence, head.seq);
                    check_field("ok", i_out.ok, head.ok);
                    check_field("fault_applied", i_out.fault_applied, head.fault);
                    check_field("rules_used", i_out.rules_used, head.used);
                    check_field("last", i_out.last, head.last);
                    n_checked++;
                end
            end

            // Register writes must come only while the block is quiet; the checker does not enforce this
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_DIR) chan_dir = i_cfg_data[0];
                else delay_ticks = i_cfg_data;
            end

            // Predict the results of each accepted input word
            if (i_in.valid && i_in.ready) begin
                case (i_in.kind)
                    KIND_ADD: begin
                        n_add++;
                        if (rule_cnt < RULE_DEPTH) begin
                            rules[rule_cnt] = '{i_in.direction, t_rule_fault'(i_in.fault_kind),
                                                i_in.packet_type, i_in.match_sequence,
                                                i_in.sequence_req, 1'b0};
                            rule_cnt++;
                            queue_word(ACT_ADD_DONE, 3'd0, 32'd0, 1'b1, REP_NONE, 1'b1);
                        end else begin
                            n_refused++;
                            queue_word(ACT_ADD_DONE, 3'd0, 32'd0, 1'b0, REP_NONE, 1'b1);
                        end
                    end
                    KIND_SEND: begin
                        n_send++;
                        predict_send(i_in.packet_type, i_in.sequence_req);
                    end
                    KIND_POLL: begin
                        n_poll++;
                        if (hold_valid) begin
                            if (hold_wait != 8'd0) begin
                                hold_wait--;
                            end else begin
                                hold_valid = 1'b0;
                                n_release++;
                                queue_word(ACT_FWD, hold_type, hold_seq, 1'b1, REP_NONE, 1'b1);
                            end
                        end
                    end
                    default: n_other++;
                endcase
            end

            if (i_run_done && !done_seen) begin
                done_seen = 1'b1;
                if (link_words.size() != 0) begin
                    report($sformatf("%0d result words never arrived", link_words.size()));
                end
                $display("covered %0d adds (%0d refused, table full), %0d sends, %0d polls,",
                         n_add, n_refused, n_send, n_poll);
                $display({"  %0d unused-kind words; faults drop %0d delay %0d dup %0d ",
                          "disc %0d, %0d releases, %0d words checked"},
                         n_other, n_drop, n_delay, n_dup, n_disc, n_release, n_checked);
            end
        end
        queued = link_words.size();
    end

endmodule

FILE: sim/tb_link_fault_injector.sv
module tb_link_fault_injector;
    import lfi_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    // covers a full-table scan plus a couple of queued commands
    localparam int SETTLE_CYCLES = 2 * RULE_DEPTH + 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_data;
    logic       run_done;
    int         fail_count;
    int         pending;

    bit         idle_on;
    logic       cur_dir;
    int         items_sent;
    int         adds_sent;
    int         quiet_cycles;

    lfi_in_if  in_ch ();
    lfi_out_if out_ch ();

    link_fault_injector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lfi_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_run_done   (run_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stall bursts, only while idle_on is set
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any word moving ends the run
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic hold_off();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Present one word and wait for it to be taken
    task automatic put_word(input logic [1:0] kind, input logic dir, input logic [1:0] fault,
                            input logic [2:0] ptype, input logic need,
                            input logic [31:0] seq);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) hold_off();
        end
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= kind;
        in_ch.direction      <= dir;
        in_ch.fault_kind     <= fault;
        in_ch.packet_type    <= ptype;
        in_ch.match_sequence <= need;
        in_ch.sequence_req   <= seq;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic put_add(input logic dir, input logic [1:0] fault, input logic [2:0] ptype,
                           input logic need, input logic [31:0] seq);
        put_word(KIND_ADD, dir, fault, ptype, need, seq);
        adds_sent++;
    endtask

    // Fields a send does not use still toggle
    task automatic put_send(input logic [2:0] ptype, input logic [31:0] seq);
        put_word(KIND_SEND, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), ptype,
                 1'($urandom_range(0, 1)), seq);
    endtask

    task automatic put_poll();
        put_word(KIND_POLL, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom);
    endtask

    function automatic logic [31:0] random_seq();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        hold_off();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Let the block go quiet, then rewrite both registers
    task automatic new_phase(input logic dir, input logic [7:0] ticks);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_DIR;
        cfg_data <= {7'd0, dir};
        @(negedge i_clk);
        cfg_idx  <= CFG_IDX_DELAY;
        cfg_data <= ticks;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_dir = dir;
    endtask

    // Random mix of words; rule-then-matching-packet pairs only while the rule budget lasts
    task automatic run_random(input int n, input int add_cap, input bit with_idle);
        int          start_cnt;
        logic        rdir;
        logic [1:0]  rfault;
        logic [2:0]  rtype;
        logic        rneed;
        logic [31:0] rseq;
        start_cnt = items_sent;
        while (items_sent - start_cnt < n) begin
            idle_on = with_idle && (((items_sent - start_cnt) % 50) < 38);
            if ($urandom_range(0, 39) == 0) wait_drained();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    if (adds_sent < add_cap) begin
                        rdir   = ($urandom_range(0, 7) == 0) ? !cur_dir : cur_dir;
                        rfault = 2'($urandom_range(0, 3));
                        rtype  = 3'($urandom_range(0, 7));
                        rneed  = 1'($urandom_range(0, 1));
                        rseq   = random_seq();
                        put_add(rdir, rfault, rtype, rneed, rseq);
                        if ($urandom_range(0, 2) == 0) put_poll();
                        put_send(rtype, rneed ? rseq : random_seq());
                        repeat ($urandom_range(0, 3)) put_poll();
                    end else begin
                        put_send(3'($urandom_range(0, 7)), random_seq());
                    end
                end
                6, 7, 8, 9, 10, 11: put_send(3'($urandom_range(0, 7)), random_seq());
                12, 13, 14, 15, 16: put_poll();
                17, 18: begin
                    if (adds_sent < add_cap) begin
                        put_add(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                random_seq());
                    end else begin
                        put_poll();
                    end
                end
                default: put_word(KIND_UNUSED, 1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)), $urandom);
            endcase
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = KIND_ADD;
        in_ch.direction      = 1'b0;
        in_ch.fault_kind     = FLT_DROP;
        in_ch.packet_type    = '0;
        in_ch.match_sequence = 1'b0;
        in_ch.sequence_req   = '0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_IDX_DIR;
        cfg_data             = '0;
        run_done             = 1'b0;
        idle_on              = 1'b1;
        cur_dir              = 1'b0;
        items_sent           = 0;
        adds_sent            = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values (direction 0, 8 ticks)
        put_send(3'd7, 32'd0);                                // empty table: passes
        put_poll();                                           // nothing held
        put_word(KIND_UNUSED, 1'b1, 2'd3, 3'd7, 1'b1, 32'hFFFF_FFFF);
        put_add(1'b0, FLT_DROP, 3'd6, 1'b1, 32'hFFFF_FFFF);
        put_send(3'd6, 32'hFFFF_FFFE);                        // sequence differs
        put_send(3'd6, 32'hFFFF_FFFF);                        // dropped
        put_add(1'b1, FLT_DUP, 3'd2, 1'b0, 32'd0);            // other direction
        put_send(3'd2, 32'd5);                                // no match here
        put_add(1'b0, FLT_DUP, 3'd2, 1'b0, 32'd0);
        put_send(3'd2, 32'h0000_1234);                        // duplicated
        put_add(1'b0, FLT_DISC, 3'd5, 1'b1, 32'd0);
        put_send(3'd5, 32'd0);                                // link closed
        put_add(1'b0, FLT_DELAY, 3'd3, 1'b0, 32'd0);
        put_add(1'b0, FLT_DELAY, 3'd0, 1'b0, 32'd0);
        put_send(3'd3, 32'hA5A5_0001);                        // held
        put_send(3'd0, 32'h8000_0000);                        // overwrites the slot
        repeat (9) put_poll();                                // eight count down, then release

        // Random phases over several register settings
        new_phase(1'b1, 8'd0);
        run_random(110, 9, 1'b1);
        new_phase(1'b0, 8'd255);
        run_random(100, 11, 1'b1);
        new_phase(1'b1, 8'($urandom_range(1, 6)));
        run_random(110, 13, 1'b1);
        new_phase(1'b0, 8'd2);
        idle_on = 1'b0;
        run_random(115, RULE_DEPTH + 8, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        run_done <= 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lfi_pkg.sv
hw/rtl/lfi_in_if.sv
hw/rtl/lfi_out_if.sv
hw/rtl/lfi_ram.sv
hw/rtl/lfi_queue.sv
hw/rtl/lfi_front.sv
hw/rtl/lfi_back.sv
hw/rtl/link_fault_injector.sv
sim/lfi_checker.sv
sim/tb_link_fault_injector.sv
